// ----- sv/pph_pkg.sv -----
// ----------------------------------------------------------------------------
// pph_pkg
// Types and codes shared by the packet pool headroom manager modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pph_pkg;

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_FREE    = 2'd1,
    ACT_PREPEND = 2'd2,
    ACT_CUT     = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_POOL_FULL = 3'd1,
    ST_NOT_BUSY  = 3'd2,
    ST_NO_ROOM   = 3'd3,
    ST_TOO_SHORT = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } fsm_t;

  // One slot descriptor as held in the slot memory.
  typedef struct packed {
    logic [6:0] offset;
    logic [6:0] length;
  } slot_entry_t;

endpackage

`default_nettype wire

// ----- sv/packet_pool_headroom_manager_top.sv -----
// ----------------------------------------------------------------------------
// packet_pool_headroom_manager_top
// Frame buffer pool manager: alloc, free, prepend headroom and cut per slot.
// ----------------------------------------------------------------------------
// For each operation, the transfer cycle reads the slot's descriptor from
// the slot memory, and the execute state that follows checks, updates and
// writes it back while loading the result register. The memory read is
// registered; the next operation is taken only after the execute state.
// A new operation is taken while the previous result still waits at the
// output; it then holds in its execute cycle until the result is taken.
// Busy marks sit in flip-flops so the lowest free slot is found directly.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_pool_headroom_manager_top
  import pph_pkg::*;
#(
  parameter int POOL_SLOTS  = 8,
  parameter int FRAME_BYTES = 127
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_action,
  input  wire logic [2:0] in_slot,
  input  wire logic [6:0] in_byte_count,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      out_status,
  output logic [2:0]      out_slot_out,
  output logic [6:0]      out_body_offset,
  output logic [6:0]      out_packet_length
);

  localparam int         IDX_W    = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam logic [7:0] FRAME_B8 = 8'(FRAME_BYTES);

  fsm_t                  state_r, state_nxt;
  logic                  exec_go;
  logic                  in_xfer;

  act_t                  op_action_r;
  logic [2:0]            op_slot_r;
  logic [6:0]            op_cnt_r;
  logic [IDX_W-1:0]      op_idx;
  logic                  slot_in_range;

  logic [POOL_SLOTS-1:0] busy_r;
  logic [IDX_W-1:0]      alloc_idx;
  logic                  any_free;

  slot_entry_t           rd_entry;
  logic                  wr_en, wr_req;
  logic [IDX_W-1:0]      wr_addr;
  slot_entry_t           wr_entry;
  logic                  busy_set, busy_clr;

  status_t               res_status;
  logic [2:0]            res_slot;
  logic [6:0]            res_off, res_len;
  logic [7:0]            sum_len;

  logic                  out_valid_r;
  status_t               out_status_r;
  logic [2:0]            out_slot_r;
  logic [6:0]            out_off_r, out_len_r;

  assign in_xfer = in_valid && in_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_xfer) state_nxt = S_EXEC;
      S_EXEC:  if (exec_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready = 1'b0;
    exec_go  = 1'b0;
    unique case (state_r)
      S_IDLE:  in_ready = 1'b1;
      S_EXEC:  exec_go  = !out_valid_r || out_ready;
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_action_r <= act_t'(in_action);
      op_slot_r   <= in_slot;
      op_cnt_r    <= in_byte_count;
    end
  end

  assign op_idx        = IDX_W'(op_slot_r);
  assign slot_in_range = (32'(op_slot_r) < POOL_SLOTS);

  // Lowest free slot
  always_comb begin
    alloc_idx = '0;
    for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
      if (!busy_r[i]) alloc_idx = IDX_W'(i);
    end
  end
  assign any_free = ~&busy_r;

  pph_slot_store #(
    .POOL_SLOTS (POOL_SLOTS),
    .IDX_W      (IDX_W)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_xfer),
    .rd_addr  (IDX_W'(in_slot)),
    .rd_entry (rd_entry),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry)
  );

  assign sum_len = {1'b0, rd_entry.length} + {1'b0, op_cnt_r};

  // Check and update the slot descriptor
  always_comb begin
    res_status = ST_OK;
    res_slot   = op_slot_r;
    res_off    = rd_entry.offset;
    res_len    = rd_entry.length;
    wr_req     = 1'b0;
    wr_addr    = op_idx;
    wr_entry   = rd_entry;
    busy_set   = 1'b0;
    busy_clr   = 1'b0;
    if (op_action_r == ACT_ALLOC) begin
      res_off = '0;
      res_len = '0;
      if (!any_free) begin
        res_status = ST_POOL_FULL;
        res_slot   = '0;
      end else begin
        res_slot = 3'(alloc_idx);
        wr_req   = 1'b1;
        wr_addr  = alloc_idx;
        wr_entry = '0;
        busy_set = 1'b1;
      end
    end else if (!slot_in_range) begin
      res_status = (op_action_r == ACT_FREE) ? ST_OK : ST_NOT_BUSY;
      res_off    = '0;
      res_len    = '0;
    end else if (op_action_r == ACT_FREE) begin
      busy_clr = 1'b1;
    end else if (!busy_r[op_idx]) begin
      res_status = ST_NOT_BUSY;
    end else if (op_action_r == ACT_PREPEND) begin
      if (sum_len > FRAME_B8) begin
        res_status = ST_NO_ROOM;
      end else begin
        // Empty packet: place the body so that it ends at the frame end.
        if (rd_entry.length == '0) begin
          res_off = 7'(FRAME_B8 - {1'b0, op_cnt_r});
          res_len = op_cnt_r;
        end else begin
          res_off = rd_entry.offset - op_cnt_r;
          res_len = 7'(sum_len);
        end
        wr_req          = 1'b1;
        wr_entry.offset = res_off;
        wr_entry.length = res_len;
      end
    end else begin
      if (rd_entry.length < op_cnt_r) begin
        res_status = ST_TOO_SHORT;
      end else begin
        res_off         = rd_entry.offset + op_cnt_r;
        res_len         = rd_entry.length - op_cnt_r;
        wr_req          = 1'b1;
        wr_entry.offset = res_off;
        wr_entry.length = res_len;
      end
    end
  end

  assign wr_en = exec_go && wr_req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
    end else if (exec_go) begin
      if (busy_set) busy_r[alloc_idx] <= 1'b1;
      if (busy_clr) busy_r[op_idx]    <= 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_status_r <= res_status;
      out_slot_r   <= res_slot;
      out_off_r    <= res_off;
      out_len_r    <= res_len;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_slot_out      = out_slot_r;
  assign out_body_offset   = out_off_r;
  assign out_packet_length = out_len_r;

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_EXEC))
    else $error("result appeared without an execute cycle");

  a_full_means_all_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_go && res_status == ST_POOL_FULL) |-> (&busy_r))
    else $error("pool full reported with a free slot");

  a_alloc_marks_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_go && busy_set) |=> busy_r[$past(alloc_idx)])
    else $error("allocated slot not marked busy");

  a_alloc_takes_free: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_go && busy_set) |-> !busy_r[alloc_idx])
    else $error("alloc picked a busy slot");

  a_cut_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_go && op_action_r == ACT_CUT && res_status == ST_OK)
      |-> (res_len <= rd_entry.length))
    else $error("cut grew the packet");

endmodule

`default_nettype wire

// ----- sv/pph_slot_store.sv -----
// ----------------------------------------------------------------------------
// pph_slot_store
// Slot descriptor memory: one write port, one read port with registered data.
// Entries never written since reset read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module pph_slot_store
  import pph_pkg::*;
#(
  parameter int POOL_SLOTS = 8,
  parameter int IDX_W      = 3
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output slot_entry_t           rd_entry,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire slot_entry_t      wr_entry
);

  slot_entry_t                mem [POOL_SLOTS];
  logic [POOL_SLOTS-1:0]      written_r;
  slot_entry_t                rd_data_r;
  logic                       rd_written_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r    <= '0;
      rd_written_r <= 1'b0;
    end else begin
      if (wr_en) begin
        written_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_written_r <= written_r[rd_addr];
      end
    end
  end

  // Untouched entries hold their reset value of zero.
  assign rd_entry = rd_written_r ? rd_data_r : '0;

endmodule

`default_nettype wire

// ----- bench/packet_pool_headroom_manager_top_tb.sv -----
// ----------------------------------------------------------------------------
// packet_pool_headroom_manager_top_tb
// Self-checking bench for the frame buffer pool manager.
// ----------------------------------------------------------------------------
// The bench feeds alloc, free, prepend and cut operations to the pool manager
// in bursts and stalls the result side on its own pattern. A pool model in
// the bench works out each answer when its operation is taken. Every result
// is compared field by field with the oldest pending answer. A directed
// opening covers the pool limits and every error status. A random part
// follows, steered by a planning copy of the pool toward busy slots and
// byte counts that fit.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module packet_pool_headroom_manager_top_tb;
  import pph_pkg::*;

  localparam int POOL_SLOTS  = 8;
  localparam int FRAME_BYTES = 127;
  localparam int RANDOM_OPS  = 800;
  localparam int IDLE_LIMIT  = 2000;

  typedef struct packed {
    act_t       action;
    logic [2:0] slot;
    logic [6:0] count;
  } pool_op_t;

  typedef struct packed {
    status_t    status;
    logic [2:0] slot;
    logic [6:0] offset;
    logic [6:0] length;
  } pool_res_t;

  typedef struct packed {
    logic [POOL_SLOTS-1:0]       busy;
    logic [POOL_SLOTS-1:0][6:0] offs;
    logic [POOL_SLOTS-1:0][6:0] lens;
  } pool_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_action = 2'd0;
  logic [2:0] in_slot = 3'd0;
  logic [6:0] in_byte_count = 7'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_status;
  logic [2:0] out_slot_out;
  logic [6:0] out_body_offset;
  logic [6:0] out_packet_length;

  pool_op_t  op_queue[$];
  pool_res_t expected_results[$];
  pool_t     plan_pool;
  pool_t     live_pool;
  pool_op_t  presented_op;
  pool_res_t answer;
  int        fail_count = 0;
  int        burst_left = 1;
  int        gap_left = 0;
  int        idle_cycles = 0;
  int        ready_cycle = 0;
  int        ready_mode = 0;

  packet_pool_headroom_manager_top #(
    .POOL_SLOTS (POOL_SLOTS),
    .FRAME_BYTES(FRAME_BYTES)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_slot          (in_slot),
    .in_byte_count    (in_byte_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_slot_out     (out_slot_out),
    .out_body_offset  (out_body_offset),
    .out_packet_length(out_packet_length)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one operation to a pool image; return the new image and the answer.
  function automatic pool_t pool_apply(input pool_t p, input pool_op_t op,
                                       output pool_res_t r);
    pool_t      q;
    int         i;
    logic [6:0] off;
    logic [6:0] len;
    q = p;
    r.status = ST_OK;
    r.slot   = op.slot;
    off      = q.offs[op.slot];
    len      = q.lens[op.slot];
    case (op.action)
      ACT_ALLOC: begin
        r.status = ST_POOL_FULL;
        r.slot   = '0;
        for (i = POOL_SLOTS - 1; i >= 0; i--) begin
          if (!q.busy[i]) begin
            r.status = ST_OK;
            r.slot   = i[2:0];
          end
        end
        if (r.status == ST_OK) begin
          q.busy[r.slot] = 1'b1;
          q.offs[r.slot] = '0;
          q.lens[r.slot] = '0;
        end
        off = '0;
        len = '0;
      end
      ACT_FREE: begin
        q.busy[op.slot] = 1'b0;
      end
      default: begin
        if (!q.busy[op.slot]) begin
          r.status = ST_NOT_BUSY;
        end else if (op.action == ACT_PREPEND) begin
          if (FRAME_BYTES - int'(len) < int'(op.count)) begin
            r.status = ST_NO_ROOM;
          end else if (len == 0) begin
            // empty packet: place it so it ends at the frame end
            len = op.count;
            off = 7'(FRAME_BYTES - int'(op.count));
          end else begin
            off = off - op.count;
            len = len + op.count;
          end
        end else begin
          if (len < op.count) begin
            r.status = ST_TOO_SHORT;
          end else begin
            len = len - op.count;
            off = off + op.count;
          end
        end
        q.offs[op.slot] = off;
        q.lens[op.slot] = len;
      end
    endcase
    r.offset = off;
    r.length = len;
    return q;
  endfunction

  task automatic queue_op(input act_t action, input int slot, input int count);
    pool_op_t  op;
    pool_res_t ignored;
    op.action = action;
    op.slot   = slot[2:0];
    op.count  = count[6:0];
    plan_pool = pool_apply(plan_pool, op, ignored);
    op_queue.push_back(op);
  endtask

  // Mostly a busy slot, now and then any slot.
  function automatic int pick_slot(input logic [POOL_SLOTS-1:0] busy);
    int s;
    s = $urandom_range(0, POOL_SLOTS - 1);
    if (busy != '0 && $urandom_range(0, 9) != 0) begin
      while (!busy[s]) s = $urandom_range(0, POOL_SLOTS - 1);
    end
    return s;
  endfunction

  task automatic queue_random_op();
    int r;
    int s;
    int len;
    r = $urandom_range(0, 99);
    s = pick_slot(plan_pool.busy);
    len = plan_pool.lens[s];
    if (r < 8) begin
      queue_op(act_t'($urandom_range(0, 3)), $urandom_range(0, 7), $urandom_range(0, 127));
    end else if (r < 30 && !(&plan_pool.busy && $urandom_range(0, 1) == 0)) begin
      queue_op(ACT_ALLOC, $urandom_range(0, 7), $urandom_range(0, 127));
    end else if (r < 45) begin
      queue_op(ACT_FREE, s, $urandom_range(0, 127));
    end else if (r < 72) begin
      if ($urandom_range(0, 99) < 85)
        queue_op(ACT_PREPEND, s, $urandom_range(0, FRAME_BYTES - len));
      else
        queue_op(ACT_PREPEND, s, $urandom_range(0, 127));
    end else begin
      if ($urandom_range(0, 99) < 85)
        queue_op(ACT_CUT, s, $urandom_range(0, len));
      else
        queue_op(ACT_CUT, s, $urandom_range(0, 127));
    end
  endtask

  initial begin
    plan_pool = '0;
    // operations on a pool with nothing allocated
    queue_op(ACT_PREPEND, 0, 5);
    queue_op(ACT_CUT, 7, 0);
    queue_op(ACT_FREE, 3, 0);
    // fill the pool, then one alloc too many
    for (int i = 0; i <= POOL_SLOTS; i++) queue_op(ACT_ALLOC, 7 - (i % 8), 127);
    queue_op(ACT_PREPEND, 0, 0);
    queue_op(ACT_PREPEND, 0, 127);
    queue_op(ACT_PREPEND, 0, 1);
    queue_op(ACT_CUT, 0, 127);
    queue_op(ACT_CUT, 0, 1);
    queue_op(ACT_PREPEND, 7, 127);
    queue_op(ACT_CUT, 7, 0);
    queue_op(ACT_PREPEND, 1, 10);
    queue_op(ACT_PREPEND, 1, 20);
    queue_op(ACT_CUT, 1, 31);
    queue_op(ACT_CUT, 1, 30);
    queue_op(ACT_FREE, 4, 0);
    queue_op(ACT_ALLOC, 0, 0);
    queue_op(ACT_FREE, 7, 0);
    for (int i = 0; i < RANDOM_OPS; i++) queue_random_op();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (op_queue.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Driver: present queued operations in bursts with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      live_pool = '0;
    end else begin
      if (in_valid && in_ready) begin
        live_pool = pool_apply(live_pool, presented_op, answer);
        expected_results.push_back(answer);
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0 || op_queue.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          presented_op = op_queue.pop_front();
          in_action     <= presented_op.action;
          in_slot       <= presented_op.slot;
          in_byte_count <= presented_op.count;
          in_valid      <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end
      end
    end
  end

  // Monitor: stall on a pattern whose mode is redrawn at random at a regular interval.
  always @(posedge clk) begin
    pool_res_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no operation pending");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            fail_count++;
          end
          if (out_slot_out !== want.slot) begin
            $error("slot_out: expected %0d, got %0d", want.slot, out_slot_out);
            fail_count++;
          end
          if (out_body_offset !== want.offset) begin
            $error("body_offset: expected %0d, got %0d", want.offset, out_body_offset);
            fail_count++;
          end
          if (out_packet_length !== want.length) begin
            $error("packet_length: expected %0d, got %0d", want.length, out_packet_length);
            fail_count++;
          end
        end
      end
      ready_cycle++;
      if (ready_cycle % 50 == 0) ready_mode = $urandom_range(0, 3);
      case (ready_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 3) != 0);
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (ready_cycle % 8 < 5);
      endcase
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

// ----- filelist.f -----
sv/pph_pkg.sv
sv/pph_slot_store.sv
sv/packet_pool_headroom_manager_top.sv
bench/packet_pool_headroom_manager_top_tb.sv
